[hw/rtl/jsms_pkg.sv]
// ----------------------------------------------------------------------------
// jsms_pkg - shared definitions for the joint setpoint mode sequencer
// Field widths, function and command codes, mode codes, register indexes,
// reset values and the divider result bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package jsms_pkg;

  localparam int JOINT_COUNT_DEF = 30;

  localparam int JIDX_W     = 5;
  localparam int POS_W      = 16;
  localparam int ACT_W      = 18;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // input function codes
  localparam logic [1:0] FUNC_MEAS = 2'd0;
  localparam logic [1:0] FUNC_ACT  = 2'd1;
  localparam logic [1:0] FUNC_DEF  = 2'd2;
  localparam logic [1:0] FUNC_TICK = 2'd3;

  // tick commands
  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_STOP = 2'd1;
  localparam logic [1:0] CMD_RAMP = 2'd2;
  localparam logic [1:0] CMD_RUN  = 2'd3;

  // modes
  localparam logic [1:0] MODE_STOP = 2'd0;
  localparam logic [1:0] MODE_RAMP = 2'd1;
  localparam logic [1:0] MODE_RUN  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_TICKS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY_PERIOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTION_SCALE  = 2'd2;

  localparam logic [15:0] RAMP_TICKS_RST    = 16'd1000;
  localparam logic [7:0]  POLICY_PERIOD_RST = 8'd10;
  localparam logic [15:0] ACTION_SCALE_RST  = 16'd1024;

  // +/-100.0 in Q8.10
  localparam logic signed [ACT_W-1:0] ACT_LIMIT     = 18'sd102400;
  localparam logic signed [ACT_W-1:0] ACT_LIMIT_NEG = -18'sd102400;

  // ramp divider: 32-bit dividend, 16-bit divisor, quotient below 2^16
  localparam int DIV_NUM_W = 32;
  localparam int DIV_DEN_W = 16;
  localparam int DIV_STEPS = 16;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic                 done;
    logic [DIV_DEN_W-1:0] quo;
  } div_res_t;

endpackage

`default_nettype wire

[hw/rtl/joint_setpoint_mode_sequencer.sv]
// ----------------------------------------------------------------------------
// joint_setpoint_mode_sequencer - per-joint setpoint sequencer
// Stores measured, default and action values per joint; on each control
// tick applies the mode command and emits one desired position per joint
// (stop: hold measured, ramp: interpolate start to default, run: default
// plus scaled action; once disabled: hold the last desired position).
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------------
//   config   | cfg_valid/cfg_ready  | cfg_index, cfg_data
//   input    | in_valid/in_ready    | func, joint_index, position, action,
//            |                      | command, disable_req
//   output   | out_valid/out_ready  | out_joint, desired_pos, mode,
//            |                      | policy_due, disabled, last_joint
//
// A load beat for a joint in range is written straight into its store. A tick
// is accepted in idle and then walks the joints one at a time (read, multiply,
// magnitude, finish, emit), with the 16-step ramp divider run between magnitude
// and finish while a ramp is in progress. in_ready is low for the whole walk.
// A full output register stalls the walk until out_ready.
// Reset (rst, synchronous) clears the stores through per-entry valid bits;
// there is no clearing pass. Config is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module joint_setpoint_mode_sequencer import jsms_pkg::*; #(
  parameter int JOINT_COUNT = JOINT_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,

  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,

  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  func,
  input  logic [JIDX_W-1:0]           joint_index,
  input  logic signed [POS_W-1:0]     position,
  input  logic signed [ACT_W-1:0]     action,
  input  logic [1:0]                  command,
  input  logic                        disable_req,

  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [JIDX_W-1:0]           out_joint,
  output logic signed [POS_W-1:0]     desired_pos,
  output logic [1:0]                  mode,
  output logic                        policy_due,
  output logic                        disabled,
  output logic                        last_joint
);

  localparam int IDX_W = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MUL,
    S_MAG,
    S_DIVGO,
    S_DIVWAIT,
    S_FIN,
    S_EMIT
  } state_t;

  function automatic logic signed [POS_W-1:0] sat16(input logic signed [25:0] v);
    logic signed [POS_W-1:0] r;
    if (v > 26'sd32767)       r = 16'sh7FFF;
    else if (v < -26'sd32768) r = 16'sh8000;
    else                      r = v[POS_W-1:0];
    return r;
  endfunction

  // configuration
  logic [15:0] ramp_ticks;
  logic [7:0]  policy_period;
  logic [15:0] act_gain;

  // sequencer state
  state_t                  state;
  logic [IDX_W-1:0]        idx;
  logic [1:0]              mode_reg;
  logic [15:0]             ramp_count;
  logic [7:0]              step_phase;
  logic                    disable_latch;
  logic                    due_reg;
  logic                    copy_pend;
  logic signed [34:0]      prod;
  logic [33:0]             mag;
  logic                    neg;
  logic signed [POS_W-1:0] base;
  logic signed [POS_W-1:0] res_val;

  // per-joint stores
  logic signed [POS_W-1:0] meas_mem  [JOINT_COUNT];
  logic signed [POS_W-1:0] start_mem [JOINT_COUNT];
  logic signed [POS_W-1:0] def_mem   [JOINT_COUNT];
  logic signed [ACT_W-1:0] act_mem   [JOINT_COUNT];
  logic signed [POS_W-1:0] des_mem   [JOINT_COUNT];
  logic [JOINT_COUNT-1:0]  meas_vld;
  logic [JOINT_COUNT-1:0]  start_vld;
  logic [JOINT_COUNT-1:0]  def_vld;
  logic [JOINT_COUNT-1:0]  act_vld;
  logic [JOINT_COUNT-1:0]  des_vld;

  logic signed [POS_W-1:0] rd_meas;
  logic signed [POS_W-1:0] rd_start;
  logic signed [POS_W-1:0] rd_def;
  logic signed [ACT_W-1:0] rd_act;
  logic signed [POS_W-1:0] rd_des;

  // output register
  logic                    out_valid_r;
  logic [JIDX_W-1:0]       out_joint_r;
  logic signed [POS_W-1:0] desired_r;
  logic [1:0]              mode_r;
  logic                    due_r;
  logic                    dis_r;
  logic                    last_r;

  // input side
  logic                    in_fire;
  logic                    tick_fire;
  logic                    ld_fire;
  logic [IDX_W-1:0]        ld_addr;
  logic signed [ACT_W-1:0] act_clip;

  // tick command
  logic [1:0]              mode_next;
  logic                    enter_ramp;
  logic                    enter_run;
  logic                    latch_next;
  logic [15:0]             rc_base;
  logic [15:0]             rc_inc;
  logic [15:0]             ramp_count_next;
  logic [7:0]              phase_base;
  logic [7:0]              per;
  logic [8:0]              phase_inc;
  logic [7:0]              phase_wrap;
  logic                    run_active;
  logic [7:0]              step_phase_next;
  logic                    due_next;

  // datapath
  logic                    ramp_done;
  logic                    last_idx;
  logic signed [POS_W-1:0] start_eff;
  logic signed [16:0]      diff;
  logic signed [17:0]      mul_a;
  logic signed [16:0]      mul_b;
  logic [34:0]             prod_abs;
  logic                    div_start;
  logic [DIV_NUM_W-1:0]    div_num;
  div_res_t                div_res;
  logic signed [17:0]      ramp_off;
  logic signed [25:0]      ramp_sum;
  logic [33:0]             rnd;
  logic signed [25:0]      run_off;
  logic signed [25:0]      run_sum;
  logic signed [POS_W-1:0] fin_val;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign tick_fire = in_fire && (func == FUNC_TICK);
  assign ld_fire   = in_fire && (func != FUNC_TICK) &&
                     ({2'b00, joint_index} < 7'(JOINT_COUNT));
  assign ld_addr   = IDX_W'(joint_index);

  always_comb begin
    if (action > ACT_LIMIT)          act_clip = ACT_LIMIT;
    else if (action < ACT_LIMIT_NEG) act_clip = ACT_LIMIT_NEG;
    else                             act_clip = action;
  end

  // ---- configuration registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_ticks    <= RAMP_TICKS_RST;
      policy_period <= POLICY_PERIOD_RST;
      act_gain      <= ACTION_SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RAMP_TICKS:    ramp_ticks    <= cfg_data;
        CFG_POLICY_PERIOD: policy_period <= cfg_data[7:0];
        CFG_ACTION_SCALE:  act_gain      <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- tick command decode ----
  always_comb begin
    enter_ramp = (command == CMD_RAMP) && (mode_reg == MODE_STOP);
    enter_run  = (command == CMD_RUN) && (mode_reg == MODE_RAMP);
    unique case (command)
      CMD_STOP: mode_next = MODE_STOP;
      CMD_RAMP: mode_next = enter_ramp ? MODE_RAMP : mode_reg;
      CMD_RUN:  mode_next = enter_run ? MODE_RUN : mode_reg;
      default:  mode_next = mode_reg;
    endcase
    latch_next = disable_latch | disable_req;

    rc_base         = enter_ramp ? 16'd0 : ramp_count;
    rc_inc          = (rc_base != 16'hFFFF) ? rc_base + 16'd1 : rc_base;
    ramp_count_next = (!latch_next && mode_next == MODE_RAMP) ? rc_inc : rc_base;

    phase_base      = enter_run ? 8'd0 : step_phase;
    per             = (policy_period == 8'd0) ? 8'd1 : policy_period;
    phase_inc       = {1'b0, phase_base} + 9'd1;
    phase_wrap      = (phase_inc >= {1'b0, per}) ? 8'd0 : phase_inc[7:0];
    run_active      = !latch_next && (mode_next == MODE_RUN);
    step_phase_next = run_active ? phase_wrap : phase_base;
    due_next        = run_active && (phase_base == 8'd0);
  end

  // ---- datapath ----
  assign ramp_done = ramp_count >= ramp_ticks;
  assign last_idx  = (idx == IDX_W'(JOINT_COUNT - 1));

  always_comb begin
    start_eff = copy_pend ? rd_meas : rd_start;
    diff      = {rd_def[POS_W-1], rd_def} - {start_eff[POS_W-1], start_eff};
    // shared multiplier: ramp distance times count, or action times gain
    if (mode_reg == MODE_RUN) begin
      mul_a = rd_act;
      mul_b = {1'b0, act_gain};
    end else begin
      mul_a = {diff[16], diff};
      mul_b = {1'b0, ramp_count};
    end
    prod_abs = prod[34] ? 35'(-prod) : 35'(prod);

    div_start = (state == S_DIVGO);
    div_num   = mag[DIV_NUM_W-1:0] + {17'd0, ramp_ticks[15:1]};

    ramp_off = neg ? -$signed({2'b00, div_res.quo}) : $signed({2'b00, div_res.quo});
    ramp_sum = 26'(base) + 26'(ramp_off);

    rnd     = mag + 34'd512;
    run_off = neg ? -$signed({2'b00, rnd[33:10]}) : $signed({2'b00, rnd[33:10]});
    run_sum = 26'(rd_def) + run_off;

    if (disable_latch) begin
      fin_val = rd_des;
    end else begin
      unique case (mode_reg)
        MODE_STOP: fin_val = rd_meas;
        MODE_RAMP: fin_val = ramp_done ? rd_def : sat16(ramp_sum);
        MODE_RUN:  fin_val = sat16(run_sum);
        default:   fin_val = rd_des;
      endcase
    end
  end

  jsms_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (ramp_ticks),
    .res   (div_res)
  );

  // ---- per-joint stores ----
  always_ff @(posedge clk) begin
    if (ld_fire) begin
      case (func)
        FUNC_MEAS: meas_mem[ld_addr] <= position;
        FUNC_ACT:  act_mem[ld_addr]  <= act_clip;
        FUNC_DEF:  def_mem[ld_addr]  <= position;
        default: ;
      endcase
    end
    if (state == S_MUL && copy_pend) start_mem[idx] <= rd_meas;
    if (state == S_FIN && !disable_latch) des_mem[idx] <= fin_val;
    if (state == S_READ) begin
      rd_meas  <= meas_vld[idx]  ? meas_mem[idx]  : '0;
      rd_start <= start_vld[idx] ? start_mem[idx] : '0;
      rd_def   <= def_vld[idx]   ? def_mem[idx]   : '0;
      rd_act   <= act_vld[idx]   ? act_mem[idx]   : '0;
      rd_des   <= des_vld[idx]   ? des_mem[idx]   : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      meas_vld  <= '0;
      start_vld <= '0;
      def_vld   <= '0;
      act_vld   <= '0;
      des_vld   <= '0;
    end else begin
      if (ld_fire) begin
        case (func)
          FUNC_MEAS: meas_vld[ld_addr] <= 1'b1;
          FUNC_ACT:  act_vld[ld_addr]  <= 1'b1;
          FUNC_DEF:  def_vld[ld_addr]  <= 1'b1;
          default: ;
        endcase
      end
      if (state == S_MUL && copy_pend) start_vld[idx] <= 1'b1;
      if (state == S_FIN && !disable_latch) des_vld[idx] <= 1'b1;
    end
  end

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      idx           <= '0;
      mode_reg      <= MODE_STOP;
      ramp_count    <= '0;
      step_phase    <= '0;
      disable_latch <= 1'b0;
      due_reg       <= 1'b0;
      copy_pend     <= 1'b0;
      out_valid_r   <= 1'b0;
      dis_r         <= 1'b0;
    end else begin
      // drop the beat once taken, unless the next one loads in its place
      if (out_valid_r && out_ready && state != S_EMIT) out_valid_r <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (tick_fire) begin
            mode_reg      <= mode_next;
            ramp_count    <= ramp_count_next;
            step_phase    <= step_phase_next;
            disable_latch <= latch_next;
            due_reg       <= due_next;
            copy_pend     <= enter_ramp;
            idx           <= '0;
            state         <= S_READ;
          end
        end
        S_READ: begin
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= mul_a * mul_b;
          base  <= start_eff;
          state <= S_MAG;
        end
        S_MAG: begin
          mag <= prod_abs[33:0];
          neg <= prod[34];
          if (!disable_latch && mode_reg == MODE_RAMP && !ramp_done) begin
            state <= S_DIVGO;
          end else begin
            state <= S_FIN;
          end
        end
        S_DIVGO: begin
          state <= S_DIVWAIT;
        end
        S_DIVWAIT: begin
          if (div_res.done) state <= S_FIN;
        end
        S_FIN: begin
          res_val <= fin_val;
          state   <= S_EMIT;
        end
        S_EMIT: begin
          // hold until the output register is free
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_joint_r <= JIDX_W'(idx);
            desired_r   <= res_val;
            mode_r      <= mode_reg;
            due_r       <= due_reg;
            dis_r       <= disable_latch;
            last_r      <= last_idx;
            if (last_idx) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_READ;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_joint   = out_joint_r;
  assign desired_pos = desired_r;
  assign mode        = mode_r;
  assign policy_due  = due_r;
  assign disabled    = dis_r;
  assign last_joint  = last_r;

endmodule

`default_nettype wire

[hw/rtl/jsms_div.sv]
// ----------------------------------------------------------------------------
// jsms_div - iterative unsigned divider
// Restoring division, one quotient bit per cycle. The caller guarantees
// that the quotient fits in DIV_STEPS bits, so the top half of the dividend
// seeds the partial remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module jsms_div import jsms_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output div_res_t             res
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] qs;
  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_DEN_W:0]   rem_sub;
  logic                 fits;

  always_comb begin
    rem_sh  = {rem, qs[DIV_DEN_W-1]};
    fits    = rem_sh >= {1'b0, den};
    rem_sub = rem_sh - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= num[DIV_NUM_W-1:DIV_NUM_W-DIV_DEN_W];
        qs   <= num[DIV_DEN_W-1:0];
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= fits ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
        qs  <= {qs[DIV_DEN_W-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res.done = done;
  assign res.quo  = qs;

endmodule

`default_nettype wire

[hw/rtl/jsms_checker.sv]
// ----------------------------------------------------------------------------
// jsms_checker - port-level checks for the joint setpoint mode sequencer
// Watches the output channel and the input ready over time.
// ----------------------------------------------------------------------------
`default_nettype none

module jsms_checker import jsms_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [JIDX_W-1:0]       out_joint,
  input logic signed [POS_W-1:0] desired_pos,
  input logic [1:0]              mode,
  input logic                    policy_due,
  input logic                    disabled,
  input logic                    last_joint
);

  // a stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(desired_pos) && $stable(out_joint))
    else $error("output beat changed while stalled");

  // after a beat that is not the last joint, the tick is still in flight
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_joint |=> out_valid || !in_ready)
    else $error("input ready while tick results are pending");

  // all beats of one tick carry the same mode and flags
  a_tick_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_joint |=>
      $stable(mode) && $stable(disabled) && $stable(policy_due))
    else $error("mode or flags changed within a tick");

  // disable latch never clears outside reset
  a_dis_sticky: assert property (@(posedge clk) disable iff (rst)
    disabled |=> disabled)
    else $error("disabled flag cleared without reset");

  // policy step only in run mode and never while disabled
  a_due_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && policy_due |-> mode == MODE_RUN && !disabled)
    else $error("policy_due outside enabled run mode");

endmodule

bind joint_setpoint_mode_sequencer jsms_checker u_jsms_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_joint   (out_joint),
  .desired_pos (desired_pos),
  .mode        (mode),
  .policy_due  (policy_due),
  .disabled    (disabled),
  .last_joint  (last_joint)
);

`default_nettype wire
